// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rotator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define QVR_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define QVR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define QVR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/qvr_pkg.sv =====
package qvr_pkg;

    // data path widths
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 14;
    localparam int P1_W       = 2 * DATA_WIDTH;        // product of two components
    localparam int T_W        = P1_W + 2;              // sum of three products
    localparam int P2_W       = DATA_WIDTH + T_W;      // second-pass product
    localparam int R_W        = P2_W + 2;              // sum of four products
    localparam int SHIFT      = 2 * FRAC_BITS;
    localparam int SAT_W      = R_W - SHIFT;           // width after the final shift

    // register port
    localparam int APB_DW     = 32;
    localparam int ADDR_W     = 4;
    localparam int IDX_W      = ADDR_W - 2;

    localparam logic [IDX_W-1:0] REG_QUAT_W = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_QUAT_X = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_QUAT_Y = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_QUAT_Z = IDX_W'(3);

    // 1.0 in the quaternion fixed-point format
    localparam logic [DATA_WIDTH-1:0] QUAT_ONE = DATA_WIDTH'(64'd1 << FRAC_BITS);

    // saturation bounds
    localparam logic signed [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] w;
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] vec_x;
        logic signed [DATA_WIDTH-1:0] vec_y;
        logic signed [DATA_WIDTH-1:0] vec_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] out_x;
        logic signed [DATA_WIDTH-1:0] out_y;
        logic signed [DATA_WIDTH-1:0] out_z;
        logic                         saturated;
    } t_vec_out;

    // intermediate quaternion t = q * (0, v)
    typedef struct packed {
        logic signed [T_W-1:0] ts;
        logic signed [T_W-1:0] tx;
        logic signed [T_W-1:0] ty;
        logic signed [T_W-1:0] tz;
    } t_tquat;

    // full-precision rotated vector
    typedef struct packed {
        logic signed [R_W-1:0] rx;
        logic signed [R_W-1:0] ry;
        logic signed [R_W-1:0] rz;
    } t_rvec;

endpackage

// ===== sv/qvr_cfg.sv =====
module qvr_cfg
    import qvr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_quat             o_quat
);

    t_quat              r_quat;
    logic               wr_en;
    logic [IDX_W-1:0]   idx;
    logic [DATA_WIDTH-1:0] rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    // quaternion registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w <= QUAT_ONE;
            r_quat.x <= '0;
            r_quat.y <= '0;
            r_quat.z <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_QUAT_W: r_quat.w <= pwdata[DATA_WIDTH-1:0];
                REG_QUAT_X: r_quat.x <= pwdata[DATA_WIDTH-1:0];
                REG_QUAT_Y: r_quat.y <= pwdata[DATA_WIDTH-1:0];
                REG_QUAT_Z: r_quat.z <= pwdata[DATA_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            REG_QUAT_W: rd_val = r_quat.w;
            REG_QUAT_X: rd_val = r_quat.x;
            REG_QUAT_Y: rd_val = r_quat.y;
            REG_QUAT_Z: rd_val = r_quat.z;
            default:    rd_val = '0;
        endcase
    end

    assign prdata = {{(APB_DW-DATA_WIDTH){1'b0}}, rd_val};
    assign o_quat = r_quat;

endmodule

// ===== sv/qvr_left_mul.sv =====
`include "assert_macros.svh"

module qvr_left_mul
    import qvr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_quat   i_quat,
    input  logic    i_valid,
    input  t_vec_in i_data,
    output logic    o_stall,
    output logic    o_valid,
    output t_tquat  o_data,
    input  logic    i_stall
);

    // product slots: 0 x*vx, 1 y*vy, 2 z*vz, 3 w*vx, 4 y*vz, 5 z*vy,
    // 6 w*vy, 7 z*vx, 8 x*vz, 9 w*vz, 10 x*vy, 11 y*vx
    logic signed [P1_W-1:0] r_prod [12];
    logic signed [P1_W-1:0] n_prod [12];
    t_tquat                 r_t;
    t_tquat                 n_t;
    logic                   r_valid_s1;
    logic                   r_valid_s2;
    logic                   ready_s1;
    logic                   ready_s2;

    // stage advance, bubbles collapse
    assign ready_s2 = !r_valid_s2 || !i_stall;
    assign ready_s1 = !r_valid_s1 || ready_s2;
    assign o_stall  = !ready_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_s1 <= 1'b0;
            r_valid_s2 <= 1'b0;
        end else begin
            if (ready_s1) begin
                r_valid_s1 <= i_valid;
            end
            if (ready_s2) begin
                r_valid_s2 <= r_valid_s1;
            end
        end
    end

    // stage 1: twelve component products
    always_comb begin
        n_prod[0]  = P1_W'(i_quat.x) * P1_W'(i_data.vec_x);
        n_prod[1]  = P1_W'(i_quat.y) * P1_W'(i_data.vec_y);
        n_prod[2]  = P1_W'(i_quat.z) * P1_W'(i_data.vec_z);
        n_prod[3]  = P1_W'(i_quat.w) * P1_W'(i_data.vec_x);
        n_prod[4]  = P1_W'(i_quat.y) * P1_W'(i_data.vec_z);
        n_prod[5]  = P1_W'(i_quat.z) * P1_W'(i_data.vec_y);
        n_prod[6]  = P1_W'(i_quat.w) * P1_W'(i_data.vec_y);
        n_prod[7]  = P1_W'(i_quat.z) * P1_W'(i_data.vec_x);
        n_prod[8]  = P1_W'(i_quat.x) * P1_W'(i_data.vec_z);
        n_prod[9]  = P1_W'(i_quat.w) * P1_W'(i_data.vec_z);
        n_prod[10] = P1_W'(i_quat.x) * P1_W'(i_data.vec_y);
        n_prod[11] = P1_W'(i_quat.y) * P1_W'(i_data.vec_x);
    end

    always_ff @(posedge i_clk) begin
        if (ready_s1 && i_valid) begin
            r_prod <= n_prod;
        end
    end

    // stage 2: sums giving t = q * (0, v)
    always_comb begin
        n_t.ts = -(T_W'(r_prod[0]) + T_W'(r_prod[1]) + T_W'(r_prod[2]));
        n_t.tx = T_W'(r_prod[3]) + T_W'(r_prod[4]) - T_W'(r_prod[5]);
        n_t.ty = T_W'(r_prod[6]) + T_W'(r_prod[7]) - T_W'(r_prod[8]);
        n_t.tz = T_W'(r_prod[9]) + T_W'(r_prod[10]) - T_W'(r_prod[11]);
    end

    always_ff @(posedge i_clk) begin
        if (ready_s2 && r_valid_s1) begin
            r_t <= n_t;
        end
    end

    assign o_valid = r_valid_s2;
    assign o_data  = r_t;

    // a request taken here is held in the first stage next cycle
    `QVR_ASSERT_NEXT(a_left_take, i_valid && !o_stall, r_valid_s1, "accepted request lost in stage 1")

endmodule

// ===== sv/qvr_right_mul.sv =====
module qvr_right_mul
    import qvr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_quat  i_quat,
    input  logic   i_valid,
    input  t_tquat i_data,
    output logic   o_stall,
    output logic   o_valid,
    output t_rvec  o_data,
    input  logic   i_stall
);

    // product slots: 0 w*tx, 1 ts*x, 2 ty*z, 3 tz*y, 4 w*ty, 5 ts*y,
    // 6 tz*x, 7 tx*z, 8 w*tz, 9 ts*z, 10 tx*y, 11 ty*x
    logic signed [P2_W-1:0] r_prod [12];
    logic signed [P2_W-1:0] n_prod [12];
    t_rvec                  r_r;
    t_rvec                  n_r;
    logic                   r_valid_s1;
    logic                   r_valid_s2;
    logic                   ready_s1;
    logic                   ready_s2;

    // stage advance, bubbles collapse
    assign ready_s2 = !r_valid_s2 || !i_stall;
    assign ready_s1 = !r_valid_s1 || ready_s2;
    assign o_stall  = !ready_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_s1 <= 1'b0;
            r_valid_s2 <= 1'b0;
        end else begin
            if (ready_s1) begin
                r_valid_s1 <= i_valid;
            end
            if (ready_s2) begin
                r_valid_s2 <= r_valid_s1;
            end
        end
    end

    // stage 3: products with conj(q)
    always_comb begin
        n_prod[0]  = P2_W'(i_quat.w) * P2_W'(i_data.tx);
        n_prod[1]  = P2_W'(i_quat.x) * P2_W'(i_data.ts);
        n_prod[2]  = P2_W'(i_quat.z) * P2_W'(i_data.ty);
        n_prod[3]  = P2_W'(i_quat.y) * P2_W'(i_data.tz);
        n_prod[4]  = P2_W'(i_quat.w) * P2_W'(i_data.ty);
        n_prod[5]  = P2_W'(i_quat.y) * P2_W'(i_data.ts);
        n_prod[6]  = P2_W'(i_quat.x) * P2_W'(i_data.tz);
        n_prod[7]  = P2_W'(i_quat.z) * P2_W'(i_data.tx);
        n_prod[8]  = P2_W'(i_quat.w) * P2_W'(i_data.tz);
        n_prod[9]  = P2_W'(i_quat.z) * P2_W'(i_data.ts);
        n_prod[10] = P2_W'(i_quat.y) * P2_W'(i_data.tx);
        n_prod[11] = P2_W'(i_quat.x) * P2_W'(i_data.ty);
    end

    always_ff @(posedge i_clk) begin
        if (ready_s1 && i_valid) begin
            r_prod <= n_prod;
        end
    end

    // stage 4: vector part w*t.p - ts*p - cross(t.p, p)
    always_comb begin
        n_r.rx = R_W'(r_prod[0]) - R_W'(r_prod[1]) - R_W'(r_prod[2]) + R_W'(r_prod[3]);
        n_r.ry = R_W'(r_prod[4]) - R_W'(r_prod[5]) - R_W'(r_prod[6]) + R_W'(r_prod[7]);
        n_r.rz = R_W'(r_prod[8]) - R_W'(r_prod[9]) - R_W'(r_prod[10]) + R_W'(r_prod[11]);
    end

    always_ff @(posedge i_clk) begin
        if (ready_s2 && r_valid_s1) begin
            r_r <= n_r;
        end
    end

    assign o_valid = r_valid_s2;
    assign o_data  = r_r;

endmodule

// ===== sv/qvr_round_sat.sv =====
`include "assert_macros.svh"

module qvr_round_sat
    import qvr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_rvec    i_data,
    output logic     o_stall,
    output logic     o_valid,
    output t_vec_out o_data,
    input  logic     i_stall
);

    t_vec_out r_out;
    t_vec_out n_out;
    logic     r_valid;
    logic     ready;
    logic     sat_x;
    logic     sat_y;
    logic     sat_z;

    // floor shift by the product fraction bits, then clip
    function automatic logic [DATA_WIDTH:0] shift_clip(input logic signed [R_W-1:0] val);
        logic signed [SAT_W-1:0] sh;
        logic                    fits;
        sh   = val[R_W-1:SHIFT];
        fits = (&sh[SAT_W-1:DATA_WIDTH-1]) || !(|sh[SAT_W-1:DATA_WIDTH-1]);
        if (fits) begin
            shift_clip = {1'b0, sh[DATA_WIDTH-1:0]};
        end else if (sh[SAT_W-1]) begin
            shift_clip = {1'b1, OUT_MIN};
        end else begin
            shift_clip = {1'b1, OUT_MAX};
        end
    endfunction

    assign ready   = !r_valid || !i_stall;
    assign o_stall = !ready;

    // stage 5: shift and saturate each component
    always_comb begin
        {sat_x, n_out.out_x} = shift_clip(i_data.rx);
        {sat_y, n_out.out_y} = shift_clip(i_data.ry);
        {sat_z, n_out.out_z} = shift_clip(i_data.rz);
        n_out.saturated      = sat_x || sat_y || sat_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

    // a flagged result carries at least one component at a bound
    `QVR_ASSERT_IMPL(a_sat_bound, o_valid && o_data.saturated, o_data.out_x == OUT_MAX || o_data.out_x == OUT_MIN || o_data.out_y == OUT_MAX || o_data.out_y == OUT_MIN || o_data.out_z == OUT_MAX || o_data.out_z == OUT_MIN, "saturated flag with no clipped component")

endmodule

// ===== sv/quaternion_vector_rotate.sv =====
// quaternion vector rotator
// rotates each 3-d vector on the input channel by the quaternion q held in
// four registers: r = q * (0, v) * conj(q), vector part, full precision,
// floor-shifted right by 2*FRAC_BITS and saturated to DATA_WIDTH bits.
// input channel: i_in_valid / o_in_stall with payload i_in_data.
// output channel: o_out_valid / i_out_stall with payload o_out_data;
// saturated is set when any component was clipped.
// registers on the apb-style port: quat_w 0x0, quat_x 0x4, quat_y 0x8,
// quat_z 0xc, signed q2.14; write them only while no request is in flight.
// o_out_valid rises once a request has passed the five register stages (the
// first loads at the accepting edge): two multiply/add stages per hamilton
// product and one shift/clip stage.
// throughput is one request per cycle while the receiver does not stall.
// reset clears all stage valid bits and loads q = (1, 0, 0, 0).
// when the receiver stalls, the result stage holds its value and the stages
// behind it keep filling into empty slots; o_in_stall rises only once every
// stage is occupied.
`include "assert_macros.svh"

module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_vec_in           i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output t_vec_out          o_out_data,
    input  logic              i_out_stall,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_quat  quat;
    logic   left_valid;
    t_tquat left_data;
    logic   right_stall;
    logic   right_valid;
    t_rvec  right_data;
    logic   sat_stall;

    // quaternion registers
    qvr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_quat  (quat)
    );

    // t = q * (0, v)
    qvr_left_mul u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stall (o_in_stall),
        .o_valid (left_valid),
        .o_data  (left_data),
        .i_stall (right_stall)
    );

    // vector part of t * conj(q)
    qvr_right_mul u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat),
        .i_valid (left_valid),
        .i_data  (left_data),
        .o_stall (right_stall),
        .o_valid (right_valid),
        .o_data  (right_data),
        .i_stall (sat_stall)
    );

    // shift, clip and output register
    qvr_round_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (right_valid),
        .i_data  (right_data),
        .o_stall (sat_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    // the input side only backs up when the result is held by the receiver
    `QVR_ASSERT_IMPL(a_stall_full, o_in_stall, o_out_valid && i_out_stall, "input stalled with room in the pipeline")

    // an empty result stage never backs up the inner stages
    `QVR_ASSERT_IMPL(a_inner_flow, !o_out_valid, !sat_stall && !right_stall, "inner stage stalled behind an empty result stage")

endmodule
